FILE: design/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg: shared types and constants of the servo bus packet deframer
// Holds store geometry, framing constants and the structs passed between the
// parser, the payload store and the replay unit.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] MIN_LEN     = 8'd2;

  // Write port of the payload store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } sbd_wr_t;

  // Replay request for a packet whose checksum matched
  typedef struct packed {
    logic       start;
    logic [7:0] id;
    logic [6:0] length;
  } sbd_job_t;

endpackage

FILE: design/servo_bus_packet_deframer.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_deframer: FF FF id length payload checksum deframer
// Finds servo bus packets in a byte stream and replays validated payloads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) takes one received byte per
//   transaction. Each byte is parsed in the cycle it is accepted; payload
//   bytes are written into a 64-entry store.
//   When the checksum byte matches the inverted sum of id, length and
//   payload, the block replays length-1 results on the output channel:
//   id, length, byte index, payload byte and a last mark on the final one.
//   Packets with a bad length or checksum produce nothing.
//   The replay request is registered after the checksum byte is accepted;
//   each result then passes through a store read and the output register,
//   and the next read issues only once the previous one has landed.
//   While a replay is in progress in_ready is low and input is blocked;
//   otherwise one byte per cycle.
//   A stall on out_ready holds the output register and pauses store reads.
//   Reset returns the parser to the header hunt and cancels any replay; the
//   store needs no clearing.
// ----------------------------------------------------------------------------
module servo_bus_packet_deframer #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_packet_id,
  output logic [6:0] out_packet_length,
  output logic [5:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic       out_last
);
  import sbd_pkg::*;

  sbd_wr_t           wr;
  sbd_job_t          job;
  logic              busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              in_fire;

  // Hold input while the store is being replayed
  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  sbd_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_rx_byte),
    .wr      (wr),
    .job_r   (job)
  );

  sbd_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  sbd_replay u_replay (
    .clk         (clk),
    .rst_n       (rst_n),
    .job         (job),
    .busy_r      (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_valid_r (out_valid),
    .out_ready   (out_ready),
    .out_id_r    (out_packet_id),
    .out_len_r   (out_packet_length),
    .out_idx_r   (out_byte_index),
    .out_byte_r  (out_payload_byte),
    .out_last_r  (out_last)
  );

`ifndef ASSERT_OFF
  // A result only appears during a replay
  a_out_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result presented outside a replay");

  // A replay never starts on top of another
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job.start |-> $past(!busy))
    else $error("replay started while busy");

  // Index stays inside the packet and last marks the final byte
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_byte_index} + 7'd2 <= out_packet_length) &&
                  (out_last == ({1'b0, out_byte_index} + 7'd2 == out_packet_length)))
    else $error("byte index or last mark inconsistent with length");

  // Input is held off while results are pending
  a_no_input_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted during replay");
`endif

endmodule

FILE: design/sbd_ram.sv
// ----------------------------------------------------------------------------
// sbd_ram: payload store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbd_ram (
  input  logic                      clk,
  input  sbd_pkg::sbd_wr_t          wr,
  input  logic                      rd_en,
  input  logic [sbd_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data_r
);
  import sbd_pkg::*;

  logic [7:0] mem_r [STORE_DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

FILE: design/sbd_parse.sv
// ----------------------------------------------------------------------------
// sbd_parse: header hunt, length check and checksum
// Walks each received byte through the frame, writes payload bytes into the
// store and raises a replay request when the checksum matches.
// ----------------------------------------------------------------------------
module sbd_parse #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  output sbd_pkg::sbd_wr_t  wr,
  output sbd_pkg::sbd_job_t job_r
);
  import sbd_pkg::*;

  localparam int         LIMIT_INT = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
  localparam logic [7:0] LEN_LIMIT = 8'(LIMIT_INT);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR2,
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] id_r, id_nxt;
  logic [6:0] len_r, len_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  sbd_job_t   job_nxt;
  logic [6:0] cnt_inc;

  assign cnt_inc = cnt_r + 7'd1;

  // Advance the frame on each accepted transaction
  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    job_nxt   = '{start: 1'b0, id: id_r, length: len_r};
    wr.en     = 1'b0;
    wr.addr   = cnt_r[ADDR_W-1:0];
    wr.data   = in_byte;
    if (in_fire) begin
      case (phase_r)
        PH_HDR2: begin
          phase_nxt = (in_byte == HEADER_BYTE) ? PH_ID : PH_HUNT;
        end
        PH_ID: begin
          id_nxt    = in_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          cnt_nxt = '0;
          if (in_byte < MIN_LEN || in_byte > LEN_LIMIT) begin
            phase_nxt = PH_HUNT;
          end else begin
            len_nxt   = in_byte[6:0];
            sum_nxt   = id_r + {1'b0, in_byte[6:0]};
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          wr.en   = 1'b1;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            // Checksum byte: compare with inverted running sum
            job_nxt.start = (~sum_r == in_byte);
            phase_nxt     = PH_HUNT;
          end else begin
            sum_nxt = sum_r + in_byte;
          end
        end
        default: begin
          phase_nxt = (in_byte == HEADER_BYTE) ? PH_HDR2 : PH_HUNT;
        end
      endcase
    end
  end

  // Hold state and the registered replay request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      id_r        <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      job_r.start <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      id_r        <= id_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      job_r.start <= job_nxt.start;
    end
    job_r.id     <= job_nxt.id;
    job_r.length <= job_nxt.length;
  end

endmodule

FILE: design/sbd_replay.sv
// ----------------------------------------------------------------------------
// sbd_replay: payload replay
// Reads the buffered payload bytes back from the store and
// presents them one per transaction through an output register.
// ----------------------------------------------------------------------------
module sbd_replay (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sbd_pkg::sbd_job_t          job,
  output logic                       busy_r,
  output logic                       rd_en,
  output logic [sbd_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output logic                       out_valid_r,
  input  logic                       out_ready,
  output logic [7:0]                 out_id_r,
  output logic [6:0]                 out_len_r,
  output logic [5:0]                 out_idx_r,
  output logic [7:0]                 out_byte_r,
  output logic                       out_last_r
);
  import sbd_pkg::*;

  logic [7:0]        id_r;
  logic [6:0]        len_r;
  logic [ADDR_W-1:0] issue_idx_r;
  logic              issue_done_r;
  logic              rd_pend_r;
  logic [ADDR_W-1:0] pend_idx_r;
  logic              pend_last_r;
  logic [ADDR_W-1:0] last_idx;
  logic              slot_free;
  logic              issue;
  logic              issue_last;

  // Issue a read only when the output register will be empty as data lands
  assign last_idx   = ADDR_W'(len_r - 7'd2);
  assign slot_free  = !out_valid_r || out_ready;
  assign issue      = busy_r && !issue_done_r && !rd_pend_r && slot_free;
  assign issue_last = (issue_idx_r == last_idx);
  assign rd_en      = issue;
  assign rd_addr    = issue_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      issue_done_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Start a new packet
      if (job.start) begin
        busy_r       <= 1'b1;
        issue_done_r <= 1'b0;
        issue_idx_r  <= '0;
        id_r         <= job.id;
        len_r        <= job.length;
      end
      // Advance the read pointer
      if (issue) begin
        issue_idx_r <= issue_idx_r + ADDR_W'(1);
        pend_idx_r  <= issue_idx_r;
        pend_last_r <= issue_last;
        if (issue_last) begin
          issue_done_r <= 1'b1;
        end
      end
      rd_pend_r <= issue;
      // Load or drain the output register
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
        out_id_r    <= id_r;
        out_len_r   <= len_r;
        out_idx_r   <= 6'(pend_idx_r);
        out_byte_r  <= rd_data;
        out_last_r  <= pend_last_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Drop busy once the final byte is taken
      if (out_valid_r && out_ready && out_last_r) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule
